FILE: rtl/hcs_pkg.sv
// ============================================================================
// hcs_pkg
// Shared types and constants for the 2-D hill-climbing step block.
// ============================================================================
package hcs_pkg;

    // Fixed field widths
    localparam int STEP_W     = 21;
    localparam int COST_W     = 48;
    localparam int MODE_W     = 2;
    localparam int PICK_W     = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COST_W-1:0] COST_MAX   = '1;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd1049;

    // Step modes
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GREEDY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd2;

    // Neighbour codes
    localparam logic [PICK_W-1:0] PICK_XP = 2'd0;
    localparam logic [PICK_W-1:0] PICK_XM = 2'd1;
    localparam logic [PICK_W-1:0] PICK_YP = 2'd2;
    localparam logic [PICK_W-1:0] PICK_YM = 2'd3;

    // Cost function select
    localparam logic GOAL_HIMMEL = 1'b0;
    localparam logic GOAL_SPHERE = 1'b1;

    // Register word index (paddr bit 2)
    localparam logic REG_IDX_STEP = 1'b0;
    localparam logic REG_IDX_GOAL = 1'b1;

    // Point fed into the cost pipeline
    typedef enum logic [2:0] {
        PT_CUR,
        PT_XP,
        PT_XM,
        PT_YP,
        PT_YM,
        PT_START
    } t_pt_sel;

    // Controller to datapath
    typedef struct packed {
        logic    issue;       // push a point into the cost pipeline
        logic    first;       // first point of this transaction
        logic    last;        // last point of this transaction
        t_pt_sel pt_sel;
        logic    load_start;  // latch the start point
        logic    commit;      // move to best point and load the result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic fold_last;      // last point's cost is folding into best
        logic pipe_busy;      // any point still in the cost pipeline
    } t_dp_sts;

endpackage

FILE: rtl/hcs_if.sv
// ============================================================================
// hcs_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface hcs_in_if import hcs_pkg::*; #(
    parameter int COORD_WIDTH = 26
) ();
    logic                          valid;
    logic                          ready;
    logic [MODE_W-1:0]             mode;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic [PICK_W-1:0]             neighbour_pick;

    modport source (output valid, mode, start_x, start_y, neighbour_pick, input ready);
    modport sink   (input valid, mode, start_x, start_y, neighbour_pick, output ready);
endinterface

interface hcs_out_if import hcs_pkg::*; #(
    parameter int COORD_WIDTH = 26
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic [COST_W-1:0]             cost;
    logic                          moved;

    modport source (output valid, pos_x, pos_y, cost, moved, input ready);
    modport sink   (input valid, pos_x, pos_y, cost, moved, output ready);
endinterface

FILE: rtl/hill_climbing_step_2d.sv
// ============================================================================
// hill_climbing_step_2d
// Hill-climbing step on a 2-D fixed-point point with APB register access.
// ============================================================================
// Keeps one point in signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS and returns
// one result transaction (point after the step, its cost, moved flag) per
// input transaction. Mode 0 loads a start point, mode 1 moves to the best of
// the four neighbours and the current point (ties go to the earlier one, in
// the order x+dx, x-dx, y+dx, y-dx, current), mode 2 moves to the picked
// neighbour only if its cost is strictly lower, mode 3 holds. Cost is
// Himmelblau or x^2+y^2 (register goal_select), saturated to 48 bits. One
// transaction is handled at a time: candidate points enter a five-stage
// cost pipeline (two squarer stages, of COORD_WIDTH and of 32x32 bits) at
// one per cycle, with 1 candidate for load and hold, 2 for mode 2 and 5 for
// mode 1. The next transaction is accepted only once the previous one has
// been committed to the result register. A pending result does not block
// acceptance of the next transaction. Registers:
// step_size at 0x0 (21 bits, reset 1049), goal_select at 0x4 (1 bit, reset 0).
// ============================================================================
module hill_climbing_step_2d import hcs_pkg::*; #(
    parameter int COORD_WIDTH = 26,
    parameter int FRAC_BITS   = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hcs_in_if.sink                i_in,
    hcs_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [STEP_W-1:0] r_step;
    logic              r_goal;
    logic              w_wr;
    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;

    // Register file
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_goal <= GOAL_HIMMEL;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_IDX_STEP: r_step <= pwdata[STEP_W-1:0];
                REG_IDX_GOAL: r_goal <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDX_STEP: prdata = APB_DATA_W'(r_step);
            REG_IDX_GOAL: prdata = APB_DATA_W'(r_goal);
            default:      prdata = '0;
        endcase
    end

    // Sequencer
    hcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_mode      (i_in.mode),
        .i_pick      (i_in.neighbour_pick),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // Datapath
    hcs_dp #(
        .CW (COORD_WIDTH),
        .FB (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .i_step    (r_step),
        .i_goal    (r_goal),
        .i_start_x (i_in.start_x),
        .i_start_y (i_in.start_y),
        .o_pos_x   (o_out.pos_x),
        .o_pos_y   (o_out.pos_y),
        .o_cost    (o_out.cost),
        .o_moved   (o_out.moved)
    );

`ifndef NO_ASSERTIONS
    // Ready for a new transaction only with the cost pipeline drained
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_sts.pipe_busy)
        else $error("input ready while cost pipeline busy");

    // One transaction at a time
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second transaction accepted back to back");

    // Last cost folds only while a transaction is in flight
    a_fold_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.fold_last |-> !i_in.ready)
        else $error("cost result with no transaction in flight");
`endif

endmodule

FILE: rtl/hcs_ctrl.sv
// ============================================================================
// hcs_ctrl
// Sequencer: accepts a transaction, issues its candidate points into the
// cost pipeline, waits for the last cost and commits the chosen point.
// ============================================================================
module hcs_ctrl import hcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [PICK_W-1:0] i_pick,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_dp_cmd           o_cmd,
    input  t_dp_sts           i_sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } t_state;

    t_state            r_state;
    logic [MODE_W-1:0] r_mode;
    logic [PICK_W-1:0] r_pick;
    logic [2:0]        r_idx;
    logic              r_out_valid;
    logic              n_out_valid;

    logic    w_accept;
    logic    w_out_free;
    logic [2:0] w_last_idx;
    t_pt_sel w_pt_sel;

    // Candidate point for position idx of the issue sequence
    function automatic t_pt_sel pick_pt(input logic [MODE_W-1:0] mode,
                                        input logic [PICK_W-1:0] pick,
                                        input logic [2:0]        idx);
        t_pt_sel sel;
        sel = PT_CUR;
        unique case (mode)
            MODE_LOAD: sel = PT_START;
            MODE_GREEDY: begin
                unique case (idx)
                    3'd0:    sel = PT_XP;
                    3'd1:    sel = PT_XM;
                    3'd2:    sel = PT_YP;
                    3'd3:    sel = PT_YM;
                    default: sel = PT_CUR;
                endcase
            end
            MODE_RANDOM: begin
                // current point first, so a tie keeps it
                if (idx == 3'd0) begin
                    sel = PT_CUR;
                end else begin
                    unique case (pick)
                        PICK_XP: sel = PT_XP;
                        PICK_XM: sel = PT_XM;
                        PICK_YP: sel = PT_YP;
                        PICK_YM: sel = PT_YM;
                        default: sel = PT_CUR;
                    endcase
                end
            end
            default: sel = PT_CUR;   // unused mode holds the point
        endcase
        return sel;
    endfunction

    // Points per transaction, minus one
    always_comb begin
        unique case (r_mode)
            MODE_GREEDY: w_last_idx = 3'd4;
            MODE_RANDOM: w_last_idx = 3'd1;
            default:     w_last_idx = 3'd0;
        endcase
    end

    assign w_pt_sel   = pick_pt(r_mode, r_pick, r_idx);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Commands to the datapath
    always_comb begin
        o_cmd.issue      = (r_state == ST_ISSUE);
        o_cmd.first      = (r_idx == 3'd0);
        o_cmd.last       = (r_idx == w_last_idx);
        o_cmd.pt_sel     = w_pt_sel;
        o_cmd.load_start = w_accept;
        o_cmd.commit     = (r_state == ST_DONE) && w_out_free;
    end

    // Output valid: cleared when taken, set on commit
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if ((r_state == ST_DONE) && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // State and output-valid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_mode  <= i_mode;
                        r_pick  <= i_pick;
                        r_idx   <= 3'd0;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    if (r_idx == w_last_idx) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                ST_WAIT: begin
                    if (i_sts.fold_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/hcs_dp.sv
// ============================================================================
// hcs_dp
// Datapath: current point, neighbour generation, five-stage cost pipeline
// with two CW- and two 32-bit squarers, best-point tracking, result register.
// ============================================================================
module hcs_dp import hcs_pkg::*; #(
    parameter int CW = 26,
    parameter int FB = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [STEP_W-1:0]    i_step,
    input  logic                 i_goal,
    input  logic signed [CW-1:0] i_start_x,
    input  logic signed [CW-1:0] i_start_y,
    output logic signed [CW-1:0] o_pos_x,
    output logic signed [CW-1:0] o_pos_y,
    output logic [COST_W-1:0]    o_cost,
    output logic                 o_moved
);

    // Neighbour sum width, square width, Himmelblau term widths
    localparam int NW   = ((CW > STEP_W) ? CW : STEP_W) + 2;
    localparam int SQW  = 2 * CW;
    localparam int AW0  = (SQW > CW + FB) ? SQW : CW + FB;
    localparam int AW   = ((AW0 > 2 * FB + 4) ? AW0 : 2 * FB + 4) + 2;
    localparam int FW   = AW - FB;
    localparam int MW   = (FW > 33) ? FW : 33;
    localparam int CMPW = (SQW + 1 > COST_W) ? SQW + 1 : COST_W;

    localparam logic signed [NW-1:0] C_MAX = (NW'(1) <<< (CW - 1)) - NW'(1);
    localparam logic signed [NW-1:0] C_MIN = -C_MAX - NW'(1);
    localparam logic signed [AW-1:0] K11   = AW'(11) <<< (2 * FB);
    localparam logic signed [AW-1:0] K7    = AW'(7) <<< (2 * FB);

    function automatic logic signed [CW-1:0] clamp_c(input logic signed [NW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > C_MAX) begin
            r = CW'(C_MAX);
        end else if (v < C_MIN) begin
            r = CW'(C_MIN);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    // Point state
    logic signed [CW-1:0] r_cur_x, r_cur_y;
    logic signed [CW-1:0] r_start_x, r_start_y;
    logic signed [CW-1:0] r_best_x, r_best_y;
    logic [COST_W-1:0]    r_best_cost;

    // Pipeline control
    logic r_s0_vld, r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic r_s0_first, r_s1_first, r_s2_first, r_s3_first, r_s4_first;
    logic r_s0_last, r_s1_last, r_s2_last, r_s3_last, r_s4_last;

    // Pipeline payload
    logic signed [CW-1:0] r_s0_x, r_s0_y, r_s1_x, r_s1_y, r_s2_x, r_s2_y;
    logic signed [CW-1:0] r_s3_x, r_s3_y, r_s4_x, r_s4_y;
    logic [SQW-1:0]       r_s1_sqx, r_s1_sqy;
    logic [31:0]          r_s2_ma, r_s2_mb;
    logic                 r_s2_sa, r_s2_sb, r_s3_sa, r_s3_sb;
    logic [COST_W-1:0]    r_s2_sph, r_s3_sph, r_s4_cost;
    logic [63:0]          r_s3_qa, r_s3_qb;

    // Result register
    logic signed [CW-1:0] r_out_x, r_out_y;
    logic [COST_W-1:0]    r_out_cost;
    logic                 r_out_moved;

    logic signed [NW-1:0] w_cx, w_cy, w_d;
    logic signed [CW-1:0] w_px, w_py;
    logic [CW-1:0]        w_ax, w_ay;
    logic [SQW-1:0]       w_sqx, w_sqy;
    logic signed [AW-1:0] w_a, w_b;
    logic signed [FW-1:0] w_af, w_bf;
    logic signed [MW-1:0] w_ae, w_be;
    logic [MW-1:0]        w_am, w_bm;
    logic [SQW:0]         w_ssum;
    logic                 w_sph_sat;
    logic [64:0]          w_hsum;
    logic                 w_him_sat;
    logic [COST_W-1:0]    w_cost;
    logic                 w_better;

    // Neighbour generation, saturated to the coordinate range
    assign w_cx = NW'(r_cur_x);
    assign w_cy = NW'(r_cur_y);
    assign w_d  = signed'(NW'(i_step));

    always_comb begin
        w_px = r_cur_x;
        w_py = r_cur_y;
        unique case (i_cmd.pt_sel)
            PT_XP:    w_px = clamp_c(w_cx + w_d);
            PT_XM:    w_px = clamp_c(w_cx - w_d);
            PT_YP:    w_py = clamp_c(w_cy + w_d);
            PT_YM:    w_py = clamp_c(w_cy - w_d);
            PT_START: begin
                w_px = r_start_x;
                w_py = r_start_y;
            end
            default: ;
        endcase
    end

    // Stage 1: square the coordinate magnitudes
    assign w_ax  = r_s0_x[CW-1] ? unsigned'(-r_s0_x) : unsigned'(r_s0_x);
    assign w_ay  = r_s0_y[CW-1] ? unsigned'(-r_s0_y) : unsigned'(r_s0_y);
    assign w_sqx = w_ax * w_ax;
    assign w_sqy = w_ay * w_ay;

    // Stage 2: Himmelblau inner terms floored to scale 2^F, sphere sum
    assign w_a  = signed'(AW'(r_s1_sqx)) + (AW'(r_s1_y) <<< FB) - K11;
    assign w_b  = signed'(AW'(r_s1_sqy)) + (AW'(r_s1_x) <<< FB) - K7;
    assign w_af = FW'(w_a >>> FB);
    assign w_bf = FW'(w_b >>> FB);
    assign w_ae = MW'(w_af);
    assign w_be = MW'(w_bf);
    assign w_am = w_ae[MW-1] ? unsigned'(-w_ae) : unsigned'(w_ae);
    assign w_bm = w_be[MW-1] ? unsigned'(-w_be) : unsigned'(w_be);

    assign w_ssum    = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy};
    assign w_sph_sat = CMPW'(w_ssum >> FB) > CMPW'(COST_MAX);

    // Stage 4: add the squared terms and saturate
    assign w_hsum    = 65'(r_s3_qa >> FB) + 65'(r_s3_qb >> FB);
    assign w_him_sat = r_s3_sa || r_s3_sb || (w_hsum > 65'(COST_MAX));
    assign w_cost    = (i_goal == GOAL_SPHERE) ? r_s3_sph
                     : (w_him_sat ? COST_MAX : w_hsum[COST_W-1:0]);

    // First point, or strictly lower cost, wins
    assign w_better = r_s4_vld && (r_s4_first || (r_s4_cost < r_best_cost));

    // Pipeline valid bits and current point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_cur_x  <= '0;
            r_cur_y  <= '0;
        end else begin
            r_s0_vld <= i_cmd.issue;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            if (i_cmd.commit) begin
                r_cur_x <= r_best_x;
                r_cur_y <= r_best_y;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_s0_x     <= w_px;
        r_s0_y     <= w_py;
        r_s0_first <= i_cmd.first;
        r_s0_last  <= i_cmd.last;

        r_s1_x     <= r_s0_x;
        r_s1_y     <= r_s0_y;
        r_s1_sqx   <= w_sqx;
        r_s1_sqy   <= w_sqy;
        r_s1_first <= r_s0_first;
        r_s1_last  <= r_s0_last;

        r_s2_x     <= r_s1_x;
        r_s2_y     <= r_s1_y;
        r_s2_ma    <= w_am[31:0];
        r_s2_mb    <= w_bm[31:0];
        r_s2_sa    <= |w_am[MW-1:32];
        r_s2_sb    <= |w_bm[MW-1:32];
        r_s2_sph   <= w_sph_sat ? COST_MAX : COST_W'(w_ssum >> FB);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;

        r_s3_x     <= r_s2_x;
        r_s3_y     <= r_s2_y;
        r_s3_qa    <= r_s2_ma * r_s2_ma;
        r_s3_qb    <= r_s2_mb * r_s2_mb;
        r_s3_sa    <= r_s2_sa;
        r_s3_sb    <= r_s2_sb;
        r_s3_sph   <= r_s2_sph;
        r_s3_first <= r_s2_first;
        r_s3_last  <= r_s2_last;

        r_s4_x     <= r_s3_x;
        r_s4_y     <= r_s3_y;
        r_s4_cost  <= w_cost;
        r_s4_first <= r_s3_first;
        r_s4_last  <= r_s3_last;
    end

    // Start point, best point and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_start_x <= i_start_x;
            r_start_y <= i_start_y;
        end
        if (w_better) begin
            r_best_x    <= r_s4_x;
            r_best_y    <= r_s4_y;
            r_best_cost <= r_s4_cost;
        end
        if (i_cmd.commit) begin
            r_out_x     <= r_best_x;
            r_out_y     <= r_best_y;
            r_out_cost  <= r_best_cost;
            r_out_moved <= (r_best_x != r_cur_x) || (r_best_y != r_cur_y);
        end
    end

    assign o_sts.fold_last = r_s4_vld && r_s4_last;
    assign o_sts.pipe_busy = r_s0_vld || r_s1_vld || r_s2_vld || r_s3_vld || r_s4_vld;

    assign o_pos_x = r_out_x;
    assign o_pos_y = r_out_y;
    assign o_cost  = r_out_cost;
    assign o_moved = r_out_moved;

endmodule

FILE: tb/tb_hill_climbing_step_2d.sv
// ============================================================================
// tb_hill_climbing_step_2d
// Self-checking testbench for the 2-D hill-climbing step block.
// ============================================================================
// Every accepted input transaction is run through a local model of the point,
// the step size and the cost function. The model queues the expected point,
// cost and moved flag, and each result transaction is checked against the
// oldest entry. A short directed list covers the coordinate extremes,
// saturation at the range edges, every mode and every neighbour pick. Random
// load-then-climb chains follow, mixed with noise items, under several register
// settings: zero, unit, large and over-wide step sizes, and both cost functions.
// Both handshake sides idle at random. One phase runs without gaps and one
// holds the result side off long enough to stall the input side.
// ============================================================================
module tb_hill_climbing_step_2d;
    import hcs_pkg::*;

    localparam int COORD_W     = 26;
    localparam int FRAC        = 20;
    localparam int IDLE_PCT    = 34;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 16;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [MODE_W-1:0] MODE_HOLD = 2'd3;

    localparam longint COORD_MAX_V = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN_V = -COORD_MAX_V - 1;
    localparam longint unsigned COST_CAP = (64'd1 << COST_W) - 64'd1;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic [PICK_W-1:0]         pick;
    } step_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [COST_W-1:0]         cost;
        logic                      moved;
    } step_res_t;

    // ------------------------------------------------------------------------
    // Point model and result checker
    // ------------------------------------------------------------------------
    class climb_scoreboard;
        longint    pt_x        = 0;
        longint    pt_y        = 0;
        longint    step_dx     = longint'(STEP_RESET);
        bit        goal_sphere = GOAL_HIMMEL;
        step_res_t pending_points[$];
        int        errors      = 0;
        int        checked     = 0;
        int        moves       = 0;
        int        mode_seen[4];

        function void set_reg(logic idx, logic [APB_DATA_W-1:0] data);
            if (idx == REG_IDX_STEP)
                step_dx = longint'(data[STEP_W-1:0]);
            else
                goal_sphere = data[0];
        endfunction

        function longint clamp_coord(longint v);
            if (v > COORD_MAX_V) return COORD_MAX_V;
            if (v < COORD_MIN_V) return COORD_MIN_V;
            return v;
        endfunction

        // floor(v*v / 2^F), anything past the cost range stands for saturation
        function longint unsigned square_scaled(longint v);
            longint unsigned m;
            m = (v < 0) ? longint'(-v) : v;
            if (m >= 64'h1_0000_0000)
                return COST_CAP + 64'd1;
            return (m * m) >> FRAC;
        endfunction

        function longint unsigned point_cost(longint px, longint py);
            longint          a;
            longint          b;
            longint          s;
            longint unsigned c;
            if (goal_sphere) begin
                s = px * px + py * py;
                c = s >>> FRAC;
            end else begin
                // floor shifts toward minus infinity
                a = (px * px + py * (longint'(1) <<< FRAC)
                     - 11 * (longint'(1) <<< (2 * FRAC))) >>> FRAC;
                b = (py * py + px * (longint'(1) <<< FRAC)
                     - 7 * (longint'(1) <<< (2 * FRAC))) >>> FRAC;
                c = square_scaled(a) + square_scaled(b);
            end
            return (c > COST_CAP) ? COST_CAP : c;
        endfunction

        function void neighbour_of(logic [PICK_W-1:0] pick, output longint nx,
                                   output longint ny);
            nx = pt_x;
            ny = pt_y;
            case (pick)
                PICK_XP: nx = clamp_coord(pt_x + step_dx);
                PICK_XM: nx = clamp_coord(pt_x - step_dx);
                PICK_YP: ny = clamp_coord(pt_y + step_dx);
                default: ny = clamp_coord(pt_y - step_dx);
            endcase
        endfunction

        // One step of the climber: updates the point, returns the result
        function step_res_t climb_once(step_req_t req);
            longint          ox;
            longint          oy;
            longint          nx;
            longint          ny;
            longint          bx;
            longint          by;
            longint unsigned best;
            longint unsigned c;
            int              k;
            step_res_t       res;
            ox = pt_x;
            oy = pt_y;
            case (req.mode)
                MODE_LOAD: begin
                    pt_x = longint'(signed'(req.start_x));
                    pt_y = longint'(signed'(req.start_y));
                end
                MODE_GREEDY: begin
                    bx   = pt_x;
                    by   = pt_y;
                    best = 0;
                    // x+dx, x-dx, y+dx, y-dx, then current; ties keep the earlier
                    for (k = 0; k < 4; k++) begin
                        neighbour_of(PICK_W'(k), nx, ny);
                        c = point_cost(nx, ny);
                        if (k == 0 || c < best) begin
                            best = c;
                            bx   = nx;
                            by   = ny;
                        end
                    end
                    if (point_cost(pt_x, pt_y) < best) begin
                        bx = pt_x;
                        by = pt_y;
                    end
                    pt_x = bx;
                    pt_y = by;
                end
                MODE_RANDOM: begin
                    neighbour_of(req.pick, nx, ny);
                    if (point_cost(pt_x, pt_y) > point_cost(nx, ny)) begin
                        pt_x = nx;
                        pt_y = ny;
                    end
                end
                default: ;  // unused mode holds the point
            endcase
            res.pos_x = pt_x[COORD_W-1:0];
            res.pos_y = pt_y[COORD_W-1:0];
            res.cost  = point_cost(pt_x, pt_y);
            res.moved = (pt_x != ox) || (pt_y != oy);
            return res;
        endfunction

        function void note_input(step_req_t req);
            step_res_t res;
            res = climb_once(req);
            mode_seen[req.mode]++;
            if (res.moved) moves++;
            pending_points.insert(pending_points.size(), res);
        endfunction

        function void check_result(step_res_t got);
            step_res_t want;
            if (pending_points.size() == 0) begin
                $error("result transaction with nothing expected: x=%0d y=%0d",
                       got.pos_x, got.pos_y);
                errors++;
                return;
            end
            want = pending_points.pop_front();
            checked++;
            if (got.pos_x !== want.pos_x) begin
                $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== want.pos_y) begin
                $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
                errors++;
            end
            if (got.cost !== want.cost) begin
                $error("cost: expected %0d, got %0d", want.cost, got.cost);
                errors++;
            end
            if (got.moved !== want.moved) begin
                $error("moved: expected %0d, got %0d", want.moved, got.moved);
                errors++;
            end
        endfunction

        function int pending();
            return pending_points.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hcs_in_if  #(.COORD_WIDTH(COORD_W)) in_if ();
    hcs_out_if #(.COORD_WIDTH(COORD_W)) out_if ();

    hill_climbing_step_2d #(
        .COORD_WIDTH (COORD_W),
        .FRAC_BITS   (FRAC)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    climb_scoreboard sb;
    bit              gaps_on = 1'b1;
    bit              hold_pending = 1'b0;
    int              hold_left = 0;
    int              settings_used = 0;
    int              cycle_count = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: random back-pressure plus an occasional long hold-off
    initial begin
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : result_mon
        step_res_t got;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.pos_x = out_if.pos_x;
            got.pos_y = out_if.pos_y;
            got.cost  = out_if.cost;
            got.moved = out_if.moved;
            sb.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input step_req_t req);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.mode           <= req.mode;
        in_if.start_x        <= req.start_x;
        in_if.start_y        <= req.start_y;
        in_if.neighbour_pick <= req.pick;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(req);
    endtask

    task automatic send(input logic [MODE_W-1:0] mode, input longint x, input longint y,
                        input logic [PICK_W-1:0] pick);
        step_req_t req;
        req.mode    = mode;
        req.start_x = x[COORD_W-1:0];
        req.start_y = y[COORD_W-1:0];
        req.pick    = pick;
        send_item(req);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic reg_write(input logic idx, input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [APB_DATA_W-1:0] step,
                             input logic [APB_DATA_W-1:0] goal);
        wait_drained();
        reg_write(REG_IDX_STEP, step);
        reg_write(REG_IDX_GOAL, goal);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic longint rand_coord();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 45)  // around the minima
            return longint'(int'($urandom_range(0, 12 << FRAC)) - (6 << FRAC));
        if (sel < 75)
            return longint'(int'($urandom_range(0, 60 << FRAC)) - (30 << FRAC));
        if (sel < 85)  // close to the range edges
            return ($urandom_range(0, 1) != 0)
                   ? COORD_MAX_V - longint'($urandom_range(0, 4096))
                   : COORD_MIN_V + longint'($urandom_range(0, 4096));
        return longint'(signed'($urandom()));
    endfunction

    task automatic run_directed();
        longint one;
        one = longint'(1) <<< FRAC;
        send(MODE_GREEDY, 0, 0, PICK_XP);            // from the reset point
        send(MODE_HOLD, -1, -1, PICK_YM);
        send(MODE_LOAD, COORD_MAX_V, COORD_MAX_V, PICK_XP);
        send(MODE_GREEDY, 0, 0, PICK_XP);            // x+dx, y+dx saturate
        send(MODE_RANDOM, 0, 0, PICK_XP);
        send(MODE_RANDOM, 0, 0, PICK_YP);
        send(MODE_LOAD, COORD_MIN_V, COORD_MIN_V, PICK_YM);
        send(MODE_GREEDY, -1, -1, PICK_YM);          // x-dx, y-dx saturate
        send(MODE_RANDOM, 0, 0, PICK_XM);
        send(MODE_RANDOM, 0, 0, PICK_YM);
        send(MODE_LOAD, 3 * one, 2 * one, PICK_XP);  // exact Himmelblau minimum
        send(MODE_GREEDY, 0, 0, PICK_XP);
        send(MODE_HOLD, 0, 0, PICK_XP);
        send(MODE_LOAD, -1, -1, PICK_XP);
        send(MODE_GREEDY, 0, 0, PICK_XP);
        send(MODE_LOAD, one, one, PICK_XP);
        send(MODE_RANDOM, -1, -1, PICK_XP);
        send(MODE_RANDOM, -1, -1, PICK_XM);
        send(MODE_RANDOM, -1, -1, PICK_YP);
        send(MODE_RANDOM, -1, -1, PICK_YM);
        send(MODE_GREEDY, 0, 0, PICK_XP);
        send(MODE_GREEDY, 0, 0, PICK_XP);
        send(MODE_LOAD, COORD_MIN_V, COORD_MAX_V, PICK_XP);
        send(MODE_GREEDY, 0, 0, PICK_XP);
    endtask

    // Load-then-climb chains with some noise and broken chains mixed in
    task automatic run_chains(input int n_items);
        int          sent;
        int          len;
        int          k;
        int unsigned sel;
        logic [MODE_W-1:0] mode;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                send(MODE_W'($urandom_range(0, 3)), longint'(signed'($urandom())),
                     longint'(signed'($urandom())), PICK_W'($urandom_range(0, 3)));
                sent++;
            end else begin
                send(MODE_LOAD, rand_coord(), rand_coord(),
                     PICK_W'($urandom_range(0, 3)));
                sent++;
                len = $urandom_range(4, 30);
                for (k = 0; k < len && sent < n_items; k++) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 60)      mode = MODE_GREEDY;
                    else if (sel < 95) mode = MODE_RANDOM;
                    else               mode = MODE_HOLD;
                    send(mode, longint'(signed'($urandom())),
                         longint'(signed'($urandom())), PICK_W'($urandom_range(0, 3)));
                    sent++;
                    // sender pause until every expected result has come back
                    if ($urandom_range(0, 99) < 2) wait_drained();
                end
            end
        end
    endtask

    initial begin
        sb = new;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.mode           = MODE_LOAD;
        in_if.start_x        = '0;
        in_if.start_y        = '0;
        in_if.neighbour_pick = PICK_XP;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: default step, Himmelblau
        settings_used = 1;
        run_directed();
        run_chains(330);

        // Zero step on the sphere: nothing may move
        configure(32'd0, 32'(GOAL_SPHERE));
        run_chains(150);

        // Over-wide writes: step wraps to its largest value, goal to Himmelblau
        configure(32'hFFFF_FFFF, 32'd2);
        gaps_on = 1'b0;
        run_chains(350);
        gaps_on = 1'b1;

        // Step of 1.0 (1048576 at FRAC 20), sphere; result side held off for a while
        configure(32'd1048576, 32'd3);
        hold_pending = 1'b1;
        run_chains(350);

        // Random small step, Himmelblau
        configure($urandom_range(1, 4096), 32'(GOAL_HIMMEL));
        run_chains(330);

        // Unit step, sphere
        configure(32'd1, 32'(GOAL_SPHERE));
        run_chains(240);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d results under %0d register settings, %0d of them moves.",
                 sb.checked, settings_used, sb.moves);
        $display("Modes seen: %0d load, %0d greedy, %0d random-neighbour, %0d hold.",
                 sb.mode_seen[0], sb.mode_seen[1], sb.mode_seen[2], sb.mode_seen[3]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: hill_climbing_step_2d.f
rtl/hcs_pkg.sv
rtl/hcs_if.sv
rtl/hcs_ctrl.sv
rtl/hcs_dp.sv
rtl/hill_climbing_step_2d.sv
tb/tb_hill_climbing_step_2d.sv
